@@ design/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clock, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/lppc_pkg.sv @@
package lppc_pkg;

   localparam int WINDOW     = 16;
   localparam int IDX_W      = $clog2(WINDOW);
   localparam int TICK_W     = 12;
   localparam int ITV_MAX    = 4095;
   localparam int SUM_W      = $clog2(WINDOW * ITV_MAX + 1);
   localparam int SAMPLE_W   = 10;
   localparam int LIMIT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0] TICK_MAX = 12'd4094;

   localparam logic [SAMPLE_W-1:0] BASELINE_RST = 10'd30;
   localparam logic [SAMPLE_W-1:0] RISE_RST     = 10'd25;
   localparam logic [SAMPLE_W-1:0] FALL_RST     = 10'd15;
   localparam logic [LIMIT_W-1:0]  LOW_RST      = 16'd139;
   localparam logic [LIMIT_W-1:0]  HIGH_RST     = 16'd613;
   localparam logic [TICK_W-1:0]   TIMEOUT_RST  = 12'd24;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BASELINE  = 3'd0,
      REG_RISE      = 3'd1,
      REG_FALL      = 3'd2,
      REG_LOW_LIM   = 3'd3,
      REG_HIGH_LIM  = 3'd4,
      REG_TIMEOUT   = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      CLASS_NONE = 2'd0,
      CLASS_LOW  = 2'd1,
      CLASS_MID  = 2'd2,
      CLASS_HIGH = 2'd3
   } damage_class_type;

endpackage

@@ design/light_pulse_period_classifier.sv @@
// Channel  | Direction | Handshake          | Payload
// req_     | in        | req_valid/req_stall | req_sample
// rsp_     | out       | rsp_valid/rsp_stall | rsp_damage_class, rsp_beam_present,
//          |           |                     | rsp_light_level, rsp_window_sum
// csr_     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One sample per cycle while rsp_stall is low; rsp_valid rises after req accept
// (input register, then result register with the tracking state update between them).
// Reset (synchronous) restores the register defaults and clears the interval window.
// rsp_stall holds the result register; the input register refills while the result
// waits only once, after that req_stall rises. csr_ready is always high.
`include "assert_macros.svh"

module light_pulse_period_classifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lppc_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_damage_class,
   output logic                                  rsp_beam_present,
   output logic                                  rsp_light_level,
   output logic [15:0]                           rsp_window_sum,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lppc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lppc_pkg::CSR_DATA_W-1:0]       csr_data
);

   // configuration
   logic [lppc_pkg::SAMPLE_W-1:0] baseline_ff, rise_ff, fall_ff;
   logic [lppc_pkg::LIMIT_W-1:0]  low_lim_ff, high_lim_ff;
   logic [lppc_pkg::TICK_W-1:0]   timeout_ff;

   // input and result stages
   logic                          in_valid_ff;
   logic [lppc_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic                          out_valid_ff;
   lppc_pkg::damage_class_type    out_class_ff, out_class_in;
   logic                          out_beam_ff;
   logic                          out_level_ff;
   logic [15:0]                   out_wsum_ff, out_wsum_in;

   // tracking state
   logic                          level_prev_ff;
   logic                          beam_on_ff, beam_on_in;
   logic [lppc_pkg::TICK_W-1:0]   ticks_ff, ticks_in;
   logic [lppc_pkg::IDX_W-1:0]    change_idx_ff, change_idx_in;
   logic [lppc_pkg::TICK_W-1:0]   store_ff [lppc_pkg::WINDOW];
   logic [lppc_pkg::SUM_W-1:0]    sum_ff, sum_in;

   logic                          out_move;
   logic                          in_take;
   logic                          level;
   logic                          change;
   logic                          complete;
   logic [lppc_pkg::SAMPLE_W:0]   thr;
   logic [lppc_pkg::TICK_W-1:0]   ticks_inc;
   logic [lppc_pkg::TICK_W-1:0]   interval;
   logic [lppc_pkg::TICK_W-1:0]   ticks_mid;

   assign out_move  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_move;
   assign in_take   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= lppc_pkg::BASELINE_RST;
         rise_ff     <= lppc_pkg::RISE_RST;
         fall_ff     <= lppc_pkg::FALL_RST;
         low_lim_ff  <= lppc_pkg::LOW_RST;
         high_lim_ff <= lppc_pkg::HIGH_RST;
         timeout_ff  <= lppc_pkg::TIMEOUT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            lppc_pkg::REG_BASELINE: baseline_ff <= csr_data[lppc_pkg::SAMPLE_W-1:0];
            lppc_pkg::REG_RISE:     rise_ff     <= csr_data[lppc_pkg::SAMPLE_W-1:0];
            lppc_pkg::REG_FALL:     fall_ff     <= csr_data[lppc_pkg::SAMPLE_W-1:0];
            lppc_pkg::REG_LOW_LIM:  low_lim_ff  <= csr_data[lppc_pkg::LIMIT_W-1:0];
            lppc_pkg::REG_HIGH_LIM: high_lim_ff <= csr_data[lppc_pkg::LIMIT_W-1:0];
            lppc_pkg::REG_TIMEOUT:  timeout_ff  <= csr_data[lppc_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      thr = {1'b0, baseline_ff} + {1'b0, (level_prev_ff ? fall_ff : rise_ff)};
      level = {1'b0, in_sample_ff} > thr;

      ticks_inc = ticks_ff;
      if (beam_on_ff && ticks_ff < lppc_pkg::TICK_MAX) begin
         ticks_inc = ticks_ff + 1'b1;
      end
      interval = ticks_inc + 1'b1;
      change   = beam_on_ff && (level != level_prev_ff);

      ticks_mid     = ticks_inc;
      change_idx_in = change_idx_ff;
      sum_in        = sum_ff;
      complete      = 1'b0;
      if (change) begin
         sum_in    = sum_ff - lppc_pkg::SUM_W'(store_ff[change_idx_ff])
                     + lppc_pkg::SUM_W'(interval);
         ticks_mid = '0;
         if (change_idx_ff == lppc_pkg::IDX_W'(lppc_pkg::WINDOW - 1)) begin
            change_idx_in = '0;
            complete      = 1'b1;
         end else begin
            change_idx_in = change_idx_ff + 1'b1;
         end
      end

      out_class_in = lppc_pkg::CLASS_NONE;
      out_wsum_in  = '0;
      if (complete) begin
         out_wsum_in = (32'(sum_in) > 32'hFFFF) ? 16'hFFFF : 16'(sum_in);
         if (out_wsum_in < low_lim_ff) begin
            out_class_in = lppc_pkg::CLASS_LOW;
         end else if (out_wsum_in > high_lim_ff) begin
            out_class_in = lppc_pkg::CLASS_HIGH;
         end else begin
            out_class_in = lppc_pkg::CLASS_MID;
         end
      end

      beam_on_in = beam_on_ff;
      ticks_in   = ticks_mid;
      if (ticks_mid > timeout_ff && !level) begin
         beam_on_in    = 1'b0;
         change_idx_in = '0;
         ticks_in      = '0;
      end
      if (!beam_on_in && level) begin
         beam_on_in = 1'b1;
         ticks_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         level_prev_ff <= 1'b0;
         beam_on_ff    <= 1'b0;
         ticks_ff      <= '0;
         change_idx_ff <= '0;
         sum_ff        <= '0;
         for (int i = 0; i < lppc_pkg::WINDOW; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (out_move) begin
            in_valid_ff <= 1'b0;
         end
         if (out_move) begin
            out_valid_ff  <= 1'b1;
            level_prev_ff <= level;
            beam_on_ff    <= beam_on_in;
            ticks_ff      <= ticks_in;
            change_idx_ff <= change_idx_in;
            sum_ff        <= sum_in;
            if (change) begin
               store_ff[change_idx_ff] <= interval;
            end
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_sample_ff <= req_sample;
      end
      if (out_move) begin
         out_class_ff <= out_class_in;
         out_beam_ff  <= beam_on_in;
         out_level_ff <= level;
         out_wsum_ff  <= out_wsum_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_damage_class = out_class_ff;
   assign rsp_beam_present = out_beam_ff;
   assign rsp_light_level  = out_level_ff;
   assign rsp_window_sum   = out_wsum_ff;

   `ASSERT_IMPL(a_sum_only_on_class, out_valid_ff && out_class_ff == lppc_pkg::CLASS_NONE,
      out_wsum_ff == 16'd0)
   `ASSERT_IMPL(a_class_needs_beam, out_valid_ff && out_class_ff != lppc_pkg::CLASS_NONE,
      out_beam_ff)
   `ASSERT_IMPL(a_idle_tracker_clear, !beam_on_ff, change_idx_ff == '0 && ticks_ff == '0)
   `ASSERT_NEXT(a_state_holds_on_stall, !out_move, $stable(ticks_ff) && $stable(sum_ff))

endmodule
